FILE: rtl/core/ffba_pkg.sv
// ----------------------------------------------------------------------------
// ffba_pkg
// Shared types and constants of the first-fit block allocator: operation
// codes, controller-to-datapath command and datapath status structs.
// ----------------------------------------------------------------------------
package ffba_pkg;

  localparam int MEM_BLOCKS_DEF    = 1024;
  localparam int MAX_PROCESSES_DEF = 256;

  localparam int MODE_W   = 2;
  localparam int ID_W     = 8;
  localparam int BLOCK_W  = $clog2(MEM_BLOCKS_DEF);
  localparam int COUNT_W  = BLOCK_W + 1;

  localparam logic [BLOCK_W-1:0] REGION_START_RST = BLOCK_W'(64);

  typedef enum logic [MODE_W-1:0] {
    MODE_ALLOC   = 2'd0,
    MODE_FREE    = 2'd1,
    MODE_COMPACT = 2'd2
  } mode_t;

  // Map scan engine: what a read pass over the owner map is doing
  typedef enum logic [1:0] {
    SCAN_NONE  = 2'd0,
    SCAN_ALLOC = 2'd1,
    SCAN_MOVE  = 2'd2,
    SCAN_FIX   = 2'd3
  } scan_t;

  // Map write sweep: where its bounds come from
  typedef enum logic [1:0] {
    SWEEP_NONE = 2'd0,
    SWEEP_FREE = 2'd1,
    SWEEP_TAIL = 2'd2
  } sweep_t;

  typedef struct packed {
    logic   latch;        // capture the input beat
    scan_t  scan_init;    // load scan pointers for the given pass
    scan_t  scan_kind;    // run the given pass this cycle
    sweep_t sweep_init;   // load sweep bounds
    logic   sweep_run;    // write one map entry if in range
    logic   sweep_mark;   // sweep writes the owner id, else empty
    logic   set_fail;     // flag no-space result
    logic   result_load;  // move result into the output register
  } cmd_t;

  typedef struct packed {
    mode_t mode;
    logic  req_bad;       // allocate request that cannot succeed
    logic  id_bad;
    logic  region_bad;
    logic  scan_done;
    logic  scan_hit;
    logic  sweep_done;
    logic  out_free;
  } stat_t;

endpackage

FILE: rtl/core/ffba_ram.sv
// ----------------------------------------------------------------------------
// ffba_ram
// Generic simple dual-port RAM: one write port, one read port, read data
// registered.
// ----------------------------------------------------------------------------
module ffba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/ffba_ctrl.sv
// ----------------------------------------------------------------------------
// ffba_ctrl
// Operation sequencer: clear pass, allocate, free and compact passes.
// ----------------------------------------------------------------------------
module ffba_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  ffba_pkg::stat_t stat,
  output ffba_pkg::cmd_t  cmd
);

  typedef enum logic [10:0] {
    S_CLEAR  = 11'b00000000001,
    S_IDLE   = 11'b00000000010,
    S_DECODE = 11'b00000000100,
    S_A_SCAN = 11'b00000001000,
    S_A_MARK = 11'b00000010000,
    S_F_LD   = 11'b00000100000,
    S_F_CLR  = 11'b00001000000,
    S_C_MOVE = 11'b00010000000,
    S_C_TAIL = 11'b00100000000,
    S_C_FIX  = 11'b01000000000,
    S_DONE   = 11'b10000000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '{latch: 1'b0, scan_init: ffba_pkg::SCAN_NONE,
                   scan_kind: ffba_pkg::SCAN_NONE, sweep_init: ffba_pkg::SWEEP_NONE,
                   sweep_run: 1'b0, sweep_mark: 1'b0, set_fail: 1'b0,
                   result_load: 1'b0};
    case (state)
      S_CLEAR: begin
        cmd.sweep_run = 1'b1;
        if (stat.sweep_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch  = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        case (stat.mode)
          ffba_pkg::MODE_ALLOC: begin
            if (stat.req_bad) begin
              cmd.set_fail = 1'b1;
              state_next   = S_DONE;
            end else begin
              cmd.scan_init = ffba_pkg::SCAN_ALLOC;
              state_next    = S_A_SCAN;
            end
          end
          ffba_pkg::MODE_FREE: begin
            state_next = stat.id_bad ? S_DONE : S_F_LD;
          end
          ffba_pkg::MODE_COMPACT: begin
            if (stat.region_bad) begin
              state_next = S_DONE;
            end else begin
              cmd.scan_init = ffba_pkg::SCAN_MOVE;
              state_next    = S_C_MOVE;
            end
          end
          default: state_next = S_DONE;
        endcase
      end
      S_A_SCAN: begin
        cmd.scan_kind = ffba_pkg::SCAN_ALLOC;
        if (stat.scan_hit) begin
          state_next = S_A_MARK;
        end else if (stat.scan_done) begin
          cmd.set_fail = 1'b1;
          state_next   = S_DONE;
        end
      end
      S_A_MARK: begin
        cmd.sweep_run  = 1'b1;
        cmd.sweep_mark = 1'b1;
        if (stat.sweep_done) state_next = S_DONE;
      end
      S_F_LD: begin
        cmd.sweep_init = ffba_pkg::SWEEP_FREE;
        state_next     = S_F_CLR;
      end
      S_F_CLR: begin
        cmd.sweep_run = 1'b1;
        if (stat.sweep_done) state_next = S_DONE;
      end
      S_C_MOVE: begin
        cmd.scan_kind = ffba_pkg::SCAN_MOVE;
        if (stat.scan_done) begin
          cmd.sweep_init = ffba_pkg::SWEEP_TAIL;
          state_next     = S_C_TAIL;
        end
      end
      S_C_TAIL: begin
        cmd.sweep_run = 1'b1;
        if (stat.sweep_done) begin
          cmd.scan_init = ffba_pkg::SCAN_FIX;
          state_next    = S_C_FIX;
        end
      end
      S_C_FIX: begin
        cmd.scan_kind = ffba_pkg::SCAN_FIX;
        if (stat.scan_done) state_next = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.result_load = 1'b1;
          state_next      = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

endmodule

FILE: rtl/core/ffba_dp.sv
// ----------------------------------------------------------------------------
// ffba_dp
// Datapath: owner map and owner tables, scan engine, write sweep, config
// register and result/output registers.
// ----------------------------------------------------------------------------
module ffba_dp #(
  parameter int MAX_PROCESSES = ffba_pkg::MAX_PROCESSES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [ffba_pkg::MODE_W-1:0]   mode,
  input  logic [ffba_pkg::ID_W-1:0]     process_id,
  input  logic [ffba_pkg::COUNT_W-1:0]  block_count,
  input  logic                          is_realtime,
  input  logic                          cfg_valid,
  input  logic [ffba_pkg::BLOCK_W-1:0]  user_region_start,
  input  ffba_pkg::cmd_t                cmd,
  output ffba_pkg::stat_t               stat,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          status,
  output logic [ffba_pkg::BLOCK_W-1:0]  start_block
);

  localparam int MEM_BLOCKS = ffba_pkg::MEM_BLOCKS_DEF;
  localparam int BW = $clog2(MEM_BLOCKS);
  localparam int PW = BW + 1;
  localparam int IW = $clog2(MAX_PROCESSES);
  localparam int MW = IW + 1;
  localparam logic [PW-1:0] MEM_END = PW'(MEM_BLOCKS);

  logic [ffba_pkg::BLOCK_W-1:0] region_q;
  ffba_pkg::mode_t              mode_q;
  logic [IW-1:0]                id_q;
  logic [PW-1:0]                count_q;
  logic                         rt_q, id_bad_q, cnt_bad_q;

  logic [PW-1:0] rd_ptr, lim, run, dst, wr_ptr, wr_hi;
  logic          pipe_vld, prev_used;
  logic [BW-1:0] pipe_addr;
  logic [IW-1:0] prev_id;
  logic          res_fail;
  logic [BW-1:0] res_start;

  logic          region_bad;
  logic [PW-1:0] u_p;
  logic          issue, hit, move_we, fix_we, fix_below, fix_begin, sweep_we;
  logic [PW-1:0] run_next, where_p;
  logic [BW-1:0] where_calc;
  logic          rd_used;
  logic [IW-1:0] rd_id;
  logic [PW:0]   free_end;
  logic [PW-1:0] free_hi;

  logic          map_we;
  logic [BW-1:0] map_waddr;
  logic [MW-1:0] map_wdata, map_rdata;
  logic          st_we;
  logic [IW-1:0] st_waddr;
  logic [BW-1:0] st_wdata, st_rdata;
  logic [PW-1:0] len_rdata;

  assign region_bad = 32'(region_q) >= MEM_BLOCKS;
  assign u_p        = PW'(region_q);

  assign rd_used    = map_rdata[IW];
  assign rd_id      = map_rdata[IW-1:0];
  assign issue      = (cmd.scan_kind != ffba_pkg::SCAN_NONE) && (rd_ptr < lim);
  assign run_next   = rd_used ? '0 : run + PW'(1);
  assign hit        = (cmd.scan_kind == ffba_pkg::SCAN_ALLOC) && pipe_vld &&
                      (run_next == count_q);
  assign where_p    = PW'(pipe_addr) + PW'(1) - count_q;
  assign where_calc = where_p[BW-1:0];
  assign move_we    = (cmd.scan_kind == ffba_pkg::SCAN_MOVE) && pipe_vld && rd_used;
  assign fix_below  = PW'(pipe_addr) < u_p;
  assign fix_begin  = !(prev_used && (prev_id == rd_id));
  assign fix_we     = (cmd.scan_kind == ffba_pkg::SCAN_FIX) && pipe_vld &&
                      !fix_below && fix_begin;
  assign sweep_we   = cmd.sweep_run && (wr_ptr < wr_hi);

  assign free_end = (PW+1)'(st_rdata) + (PW+1)'(len_rdata);
  assign free_hi  = (free_end > (PW+1)'(MEM_BLOCKS)) ? MEM_END : free_end[PW-1:0];

  always_comb begin
    map_we    = sweep_we || move_we;
    map_waddr = sweep_we ? wr_ptr[BW-1:0] : dst[BW-1:0];
    map_wdata = sweep_we ? (cmd.sweep_mark ? {1'b1, id_q} : '0) : map_rdata;
    st_we     = hit || fix_we;
    st_waddr  = hit ? id_q : rd_id;
    st_wdata  = hit ? where_calc : pipe_addr;
  end

  ffba_ram #(.WIDTH(MW), .DEPTH(MEM_BLOCKS)) u_map (
    .clk(clk), .we(map_we), .waddr(map_waddr), .wdata(map_wdata),
    .raddr(rd_ptr[BW-1:0]), .rdata(map_rdata)
  );

  ffba_ram #(.WIDTH(BW), .DEPTH(MAX_PROCESSES)) u_start (
    .clk(clk), .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
    .raddr(id_q), .rdata(st_rdata)
  );

  ffba_ram #(.WIDTH(PW), .DEPTH(MAX_PROCESSES)) u_len (
    .clk(clk), .we(hit), .waddr(id_q), .wdata(count_q),
    .raddr(id_q), .rdata(len_rdata)
  );

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      region_q  <= ffba_pkg::REGION_START_RST;
      out_valid <= 1'b0;
      pipe_vld  <= 1'b0;
      wr_ptr    <= '0;
      wr_hi     <= MEM_END;
    end else begin
      if (cfg_valid) region_q <= user_region_start;
      if (cmd.result_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      pipe_vld <= issue;
      if (hit) begin
        wr_ptr <= where_p;
        wr_hi  <= where_p + count_q;
      end else begin
        case (cmd.sweep_init)
          ffba_pkg::SWEEP_FREE: begin
            wr_ptr <= PW'(st_rdata);
            wr_hi  <= free_hi;
          end
          ffba_pkg::SWEEP_TAIL: begin
            wr_ptr <= dst;
            wr_hi  <= MEM_END;
          end
          default: begin
            if (sweep_we) wr_ptr <= wr_ptr + PW'(1);
          end
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      mode_q    <= ffba_pkg::mode_t'(mode);
      id_q      <= IW'(process_id);
      count_q   <= PW'(block_count);
      rt_q      <= is_realtime;
      id_bad_q  <= 32'(process_id) >= MAX_PROCESSES;
      cnt_bad_q <= (block_count == '0) || (32'(block_count) > MEM_BLOCKS);
      res_fail  <= 1'b0;
      res_start <= '0;
    end
    if (cmd.set_fail) res_fail <= 1'b1;
    if (hit) res_start <= where_calc;

    case (cmd.scan_init)
      ffba_pkg::SCAN_ALLOC: begin
        rd_ptr <= rt_q ? '0 : u_p;
        lim    <= MEM_END;
        run    <= '0;
      end
      ffba_pkg::SCAN_MOVE: begin
        rd_ptr <= u_p;
        lim    <= MEM_END;
        dst    <= u_p;
      end
      ffba_pkg::SCAN_FIX: begin
        rd_ptr    <= (u_p != '0) ? u_p - PW'(1) : u_p;
        lim       <= dst;
        prev_used <= 1'b0;
      end
      default: begin
        if (issue) rd_ptr <= rd_ptr + PW'(1);
        if (pipe_vld) run <= run_next;
        if (move_we) dst <= dst + PW'(1);
        if ((cmd.scan_kind == ffba_pkg::SCAN_FIX) && pipe_vld) begin
          prev_used <= rd_used;
          prev_id   <= rd_id;
        end
      end
    endcase
    pipe_addr <= rd_ptr[BW-1:0];

    if (cmd.result_load) begin
      status      <= res_fail;
      start_block <= ffba_pkg::BLOCK_W'(res_start);
    end
  end

  always_comb begin
    stat.mode       = mode_q;
    stat.id_bad     = id_bad_q;
    stat.region_bad = region_bad;
    stat.req_bad    = id_bad_q || cnt_bad_q || (!rt_q && region_bad);
    stat.scan_done  = !issue && !pipe_vld;
    stat.scan_hit   = hit;
    stat.sweep_done = !(wr_ptr < wr_hi);
    stat.out_free   = !out_valid || out_ready;
  end

endmodule

FILE: rtl/core/first_fit_block_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_block_allocator
// First-fit contiguous block allocator with free and user-region compaction.
// ----------------------------------------------------------------------------
// The block keeps an owner map of MEM_BLOCKS entries in a single RAM with one
// write and one registered read port, and handles one operation at a time.
// MEM_BLOCKS is a package constant that also sets the block and count port
// widths. After reset it runs a clearing pass over all MEM_BLOCKS entries,
// during which in_ready stays low (configuration writes are still taken).
// Every operation is bound by that one map port: allocate scans for a run
// of block_count free blocks and then marks it; a rejected allocate goes
// straight to its result; free empties the freed length; compact runs
// one map scan to slide blocks down, then a sweep that empties the tail
// and a scan that fixes owner starts, which together cover the region once
// more. A finished result waits in an output register; the next beat is
// taken as soon as the result is loaded there.
// ----------------------------------------------------------------------------
module first_fit_block_allocator #(
  parameter int MAX_PROCESSES = ffba_pkg::MAX_PROCESSES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // request channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [ffba_pkg::MODE_W-1:0]   mode,
  input  logic [ffba_pkg::ID_W-1:0]     process_id,
  input  logic [ffba_pkg::COUNT_W-1:0]  block_count,
  input  logic                          is_realtime,
  // result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          status,
  output logic [ffba_pkg::BLOCK_W-1:0]  start_block,
  // configuration write channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ffba_pkg::BLOCK_W-1:0]  user_region_start
);

  ffba_pkg::cmd_t  cmd;
  ffba_pkg::stat_t stat;

  // Register writes never stall
  assign cfg_ready = 1'b1;

  // Sequencer: steps through passes over the map
  ffba_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Map, tables, pointers and result registers
  ffba_dp #(
    .MAX_PROCESSES (MAX_PROCESSES)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .mode              (mode),
    .process_id        (process_id),
    .block_count       (block_count),
    .is_realtime       (is_realtime),
    .cfg_valid         (cfg_valid),
    .user_region_start (user_region_start),
    .cmd               (cmd),
    .stat              (stat),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .status            (status),
    .start_block       (start_block)
  );

endmodule

FILE: rtl/core/ffba_checker.sv
// ----------------------------------------------------------------------------
// ffba_checker
// Port-level checks of the allocator, attached by bind.
// ----------------------------------------------------------------------------
module ffba_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic                         status,
  input logic [ffba_pkg::BLOCK_W-1:0] start_block
);

  // One operation at a time: ready drops after a beat is taken
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("in_ready held high after a request beat");

  // A failed allocation never reports a start block
  a_fail_zero_start: assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> start_block == '0)
    else $error("no-space result with nonzero start_block");

  // No result appears out of reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("out_valid after reset");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(start_block))
    else $error("result changed while stalled");

endmodule

bind first_fit_block_allocator ffba_checker u_ffba_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .status      (status),
  .start_block (start_block)
);

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the first-fit block allocator. A cycle-free
// predictor keeps its own owner map, per-id start/length records and region
// start, computes each result beat, and a monitor compares accepted results
// field by field. Stimulus is a directed opening followed by random
// allocate/free/compact traffic across several region-start settings.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NBLK = ffba_pkg::MEM_BLOCKS_DEF;
  localparam int NPID = 256;
  localparam int HOLD_CYCLES = 20000;
  localparam logic [ffba_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;

  typedef struct packed {
    logic [ffba_pkg::MODE_W-1:0]  op;
    logic [ffba_pkg::ID_W-1:0]    pid;
    logic [ffba_pkg::COUNT_W-1:0] cnt;
    logic                         rt;
  } req_t;

  typedef struct packed {
    logic                         st;
    logic [ffba_pkg::BLOCK_W-1:0] blk;
  } rsp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0, in_ready;
  logic [ffba_pkg::MODE_W-1:0] mode = '0;
  logic [ffba_pkg::ID_W-1:0] process_id = '0;
  logic [ffba_pkg::COUNT_W-1:0] block_count = '0;
  logic is_realtime = 1'b0;
  logic out_valid, out_ready = 1'b0, status;
  logic [ffba_pkg::BLOCK_W-1:0] start_block;
  logic cfg_valid = 1'b0, cfg_ready;
  logic [ffba_pkg::BLOCK_W-1:0] user_region_start = '0;

  first_fit_block_allocator dut (.*);

  // predictor state
  bit          map_used [NBLK];
  int unsigned map_id   [NBLK];
  int unsigned rec_start[NPID];
  int unsigned rec_len  [NPID];
  bit          rec_set  [NPID];
  int unsigned region = 64;

  req_t pending_reqs[$];
  rsp_t expected_rsps[$];
  int   errors = 0;
  bit   hold_go = 1'b0;
  bit   hold_done = 1'b0;
  int   hold_cnt = 0;
  logic hold_off;
  int   burst_left = 0, gap_left = 0;
  logic in_ready_q = 1'b0;

  assign hold_off = hold_go && !hold_done;

  task automatic report(input string what);
    errors++;
    $display("mismatch: %s", what);
  endtask

  function automatic bit first_fit(input int unsigned from, input int unsigned cnt,
                                   output int unsigned where);
    int unsigned run;
    run = 0;
    where = 0;
    if (cnt == 0 || cnt > NBLK) return 1'b0;
    for (int unsigned i = from; i < NBLK; i++) begin
      run = map_used[i] ? 0 : run + 1;
      if (run == cnt) begin
        where = i + 1 - cnt;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic void slide_down();
    int unsigned dst, pid;
    bit begins;
    dst = region;
    if (region >= NBLK) return;
    for (int unsigned i = region; i < NBLK; i++) begin
      if (map_used[i]) begin
        pid = map_id[i];
        map_used[i] = 1'b0;
        map_id[i] = 0;
        map_used[dst] = 1'b1;
        map_id[dst] = pid;
        dst++;
      end
    end
    for (int unsigned i = region; i < dst; i++) begin
      pid = map_id[i];
      if (i == region)
        begins = !(region > 0 && map_used[region-1] && map_id[region-1] == pid);
      else
        begins = map_id[i-1] != pid;
      if (begins && pid < NPID) rec_start[pid] = i;
    end
  endfunction

  function automatic rsp_t allocate_result(input req_t r);
    rsp_t o;
    int unsigned where, e;
    o = '0;
    case (r.op)
      ffba_pkg::MODE_ALLOC: begin
        if (first_fit(r.rt ? 0 : region, r.cnt, where)) begin
          for (int unsigned i = where; i < where + r.cnt; i++) begin
            map_used[i] = 1'b1;
            map_id[i] = r.pid;
          end
          rec_start[r.pid] = where;
          rec_len[r.pid] = r.cnt;
          rec_set[r.pid] = 1'b1;
          o.blk = where[ffba_pkg::BLOCK_W-1:0];
        end else begin
          o.st = 1'b1;
        end
      end
      ffba_pkg::MODE_FREE: begin
        e = rec_start[r.pid] + rec_len[r.pid];
        if (e > NBLK) e = NBLK;
        for (int unsigned i = rec_start[r.pid]; i < e; i++) begin
          map_used[i] = 1'b0;
          map_id[i] = 0;
        end
      end
      ffba_pkg::MODE_COMPACT: slide_down();
      default: ;
    endcase
    return o;
  endfunction

  // driver: bursts with random gaps; drop the front item once it is taken
  always @(posedge clk) begin
    if (in_valid && in_ready) begin
      void'(pending_reqs.pop_front());
    end
  end

  always @(negedge clk) begin
    if (!rst && (!in_valid || in_ready_q)) begin
      if (pending_reqs.size() > 0) begin
        if (burst_left == 0 && gap_left == 0) begin
          burst_left = $urandom_range(1, 12);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
        if (gap_left > 0 && !hold_off) begin
          gap_left--;
          in_valid <= 1'b0;
        end else begin
          req_t r;
          r = pending_reqs[0];
          if (burst_left > 0) burst_left--;
          in_valid <= 1'b1;
          mode <= r.op;
          process_id <= r.pid;
          block_count <= r.cnt;
          is_realtime <= r.rt;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // remember whether the current beat was taken at the last rising edge
  always @(posedge clk) in_ready_q <= in_valid && in_ready;

  // receiver stall pattern, plus one long hold-off counted here
  int stall_phase = 0;
  always @(negedge clk) begin
    stall_phase <= stall_phase + 1;
    if (hold_off) begin
      out_ready <= 1'b0;
      if (hold_cnt == HOLD_CYCLES - 1) hold_done <= 1'b1;
      else hold_cnt <= hold_cnt + 1;
    end
    else if (stall_phase % 64 < 20) out_ready <= 1'b1;
    else out_ready <= ($urandom_range(0, 2) != 0);
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      rsp_t e;
      if (expected_rsps.size() == 0) begin
        report("result beat with nothing expected");
      end else begin
        e = expected_rsps.pop_front();
        if (status !== e.st)
          report($sformatf("status got %b want %b", status, e.st));
        if (start_block !== e.blk)
          report($sformatf("start_block got %0d want %0d", start_block, e.blk));
      end
    end
  end

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #60_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // queue a request and predict its result; items are taken in order and the
  // region start only changes while nothing is queued
  task automatic push(input logic [ffba_pkg::MODE_W-1:0] op, input int pid,
                      input int cnt, input bit rt);
    req_t r;
    r.op = op;
    r.pid = pid[ffba_pkg::ID_W-1:0];
    r.cnt = cnt[ffba_pkg::COUNT_W-1:0];
    r.rt = rt;
    pending_reqs.push_back(r);
    expected_rsps.push_back(allocate_result(r));
  endtask

  // frees only ids whose records were written by a successful allocate
  task automatic push_random(input int n);
    int k, pid;
    for (int j = 0; j < n; j++) begin
      k = $urandom_range(0, 99);
      pid = $urandom_range(0, NPID-1);
      if (k < 55) begin
        int c;
        c = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 2047) : $urandom_range(1, 40);
        push(ffba_pkg::MODE_ALLOC, pid, c, $urandom_range(0, 1));
      end else if (k < 85) begin
        for (int t = 0; t < 8 && !rec_set[pid]; t++) pid = $urandom_range(0, NPID-1);
        if (rec_set[pid])
          push(ffba_pkg::MODE_FREE, pid, $urandom_range(0, 2047), $urandom_range(0, 1));
        else
          push(ffba_pkg::MODE_COMPACT, pid, $urandom_range(0, 2047), $urandom_range(0, 1));
      end else if (k < 95) begin
        push(ffba_pkg::MODE_COMPACT, pid, $urandom_range(0, 2047), $urandom_range(0, 1));
      end else begin
        push(MODE_UNUSED, pid, $urandom_range(0, 2047), $urandom_range(0, 1));
      end
    end
  endtask

  task automatic drain();
    while (pending_reqs.size() > 0 || in_valid || expected_rsps.size() > 0)
      @(posedge clk);
    repeat (4000) @(posedge clk);
  endtask

  task automatic write_region(input int v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    user_region_start <= v[ffba_pkg::BLOCK_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    region = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int settings[5] = '{0, 1023, 300, 1, 64};
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed opening, default region start
    push(ffba_pkg::MODE_ALLOC, 0, 0, 0);           // zero count
    push(ffba_pkg::MODE_ALLOC, 1, 2047, 1);        // larger than memory
    push(ffba_pkg::MODE_ALLOC, 2, 1024, 1);        // whole memory
    push(ffba_pkg::MODE_FREE, 2, 0, 0);
    push(ffba_pkg::MODE_ALLOC, 255, 1, 1);
    push(ffba_pkg::MODE_ALLOC, 3, 960, 0);         // fills user region exactly
    push(ffba_pkg::MODE_ALLOC, 4, 1, 0);           // no space
    push(ffba_pkg::MODE_ALLOC, 5, 40, 1);          // realtime below region
    push(ffba_pkg::MODE_ALLOC, 6, 30, 1);          // no space, gap below region too short
    push(ffba_pkg::MODE_FREE, 3, 1365, 1);
    push(ffba_pkg::MODE_ALLOC, 7, 10, 0);
    push(ffba_pkg::MODE_ALLOC, 7, 10, 0);          // same id twice
    push(ffba_pkg::MODE_FREE, 255, 0, 0);
    push(ffba_pkg::MODE_COMPACT, 170, 1365, 1);
    push(MODE_UNUSED, 85, 682, 0);                 // unused mode
    // long receiver hold-off while the sender keeps offering
    push_random(20);
    hold_go = 1'b1;
    wait (hold_done);
    drain();

    foreach (settings[s]) begin
      write_region(settings[s]);
      push_random(85);
      drain();
    end

    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
